// ===== rtl/pcb_pkg.sv =====
// shared types, constants and helper functions of the pinhole camera geometry unit
package pcb_pkg;

	localparam int IMAGE_HEIGHT = 480;
	localparam int ENT_W = 21;
	localparam int REG_W = 3 * ENT_W;
	localparam int CFG_IW = 4;
	localparam int NW = 80;
	localparam int DW = 63;
	localparam int QW = 33;
	localparam int WK = DW + QW;
	localparam int DIV_LAT = QW + 2;

	localparam logic signed [31:0] ONE_Q16 = 32'sd65536;
	localparam logic signed [33:0] FLIP_BASE = 34'(IMAGE_HEIGHT - 1) <<< 16;

	localparam logic [CFG_IW-1:0] REG_INTR0 = 4'd0;
	localparam logic [CFG_IW-1:0] REG_INTR1 = 4'd1;
	localparam logic [CFG_IW-1:0] REG_INTR2 = 4'd2;
	localparam logic [CFG_IW-1:0] REG_ROT0 = 4'd3;
	localparam logic [CFG_IW-1:0] REG_ROT1 = 4'd4;
	localparam logic [CFG_IW-1:0] REG_ROT2 = 4'd5;
	localparam logic [CFG_IW-1:0] REG_TRANS_L = 4'd6;
	localparam logic [CFG_IW-1:0] REG_TRANS_R = 4'd7;

	typedef enum logic [1:0] {
		CMD_PROJECT = 2'd0,
		CMD_BACKPROJECT = 2'd1,
		CMD_FLIP = 2'd2
	} cmd_t;

	typedef logic signed [ENT_W-1:0] ent_t;

	typedef struct packed {
		logic [2:0][REG_W-1:0] kr;
		logic [2:0][REG_W-1:0] rr;
		logic [1:0][REG_W-1:0] tr;
	} cfg_t;

	typedef struct packed {
		cmd_t cmd;
		logic cam;
		logic fault;
		logic signed [31:0] rx;
		logic signed [31:0] ry;
		logic signed [31:0] rz;
		logic signed [33:0] a0;
		logic signed [31:0] a2;
	} side_t;

	function automatic ent_t ent(input logic [REG_W-1:0] r, input int j);
		return ent_t'(r[ENT_W*j +: ENT_W]);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647)
			return 32'sh7fffffff;
		else if (v < -64'sd2147483648)
			return 32'sh80000000;
		else
			return v[31:0];
	endfunction

	function automatic logic signed [39:0] sat40(input logic signed [63:0] v);
		if (v > 64'sd549755813887)
			return 40'sh7fffffffff;
		else if (v < -64'sd549755813888)
			return 40'sh8000000000;
		else
			return v[39:0];
	endfunction

	// signed, saturated form of a magnitude quotient
	function automatic logic signed [31:0] qsat(input logic [QW-1:0] q, input logic ovf,
		input logic neg);
		if (!neg) begin
			if (ovf || q[QW-1] || q[31])
				return 32'sh7fffffff;
			else
				return q[31:0];
		end else begin
			if (ovf || q[QW-1] || (q[31] && q[30:0] != 31'd0))
				return 32'sh80000000;
			else
				return -q[31:0];
		end
	endfunction

endpackage

// ===== rtl/pcb_regs.sv =====
// configuration register file for matrices and translations
module pcb_regs import pcb_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic wr_valid,
	output logic wr_ready,
	input logic [CFG_IW-1:0] wr_index,
	input logic [REG_W-1:0] wr_data,
	output cfg_t cfg
);

	cfg_t cfg_q;

	assign wr_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_valid) begin
			unique case (wr_index)
				REG_INTR0: cfg_q.kr[0] <= wr_data;
				REG_INTR1: cfg_q.kr[1] <= wr_data;
				REG_INTR2: cfg_q.kr[2] <= wr_data;
				REG_ROT0: cfg_q.rr[0] <= wr_data;
				REG_ROT1: cfg_q.rr[1] <= wr_data;
				REG_ROT2: cfg_q.rr[2] <= wr_data;
				REG_TRANS_L: cfg_q.tr[0] <= wr_data;
				REG_TRANS_R: cfg_q.tr[1] <= wr_data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

endmodule

// ===== rtl/pcb_div_lane.sv =====
// pipelined restoring divider lane, one quotient bit per stage
module pcb_div_lane import pcb_pkg::*; (
	input logic clk,
	input logic en,
	input logic [NW-1:0] num,
	input logic [DW-1:0] den,
	input logic neg,
	output logic [QW-1:0] quo,
	output logic ovf,
	output logic neg_out
);

	logic [NW-1:0] rem_s [0:DIV_LAT-2];
	logic [DW-1:0] den_s [0:DIV_LAT-2];
	logic [QW-1:0] quo_s [0:DIV_LAT-1];
	logic ovf_s [0:DIV_LAT-1];
	logic neg_s [0:DIV_LAT-1];

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= num;
			den_s[0] <= den;
			quo_s[0] <= '0;
			ovf_s[0] <= 1'b0;
			neg_s[0] <= neg;
		end
	end

	// quotient too large for the kept bits
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[1] <= rem_s[0];
			den_s[1] <= den_s[0];
			quo_s[1] <= '0;
			ovf_s[1] <= WK'(rem_s[0]) >= (WK'(den_s[0]) << QW);
			neg_s[1] <= neg_s[0];
		end
	end

	for (genvar k = 2; k < DIV_LAT; k++) begin : g_step
		localparam int B = DIV_LAT - 1 - k;
		logic [WK-1:0] shifted;
		logic [WK-1:0] diff;
		logic take;

		assign shifted = WK'(den_s[k-1]) << B;
		assign diff = WK'(rem_s[k-1]) - shifted;
		assign take = !ovf_s[k-1] && (WK'(rem_s[k-1]) >= shifted);

		always_ff @(posedge clk) begin
			if (en) begin
				quo_s[k] <= quo_s[k-1] | (take ? (QW'(1) << B) : QW'(0));
				ovf_s[k] <= ovf_s[k-1];
				neg_s[k] <= neg_s[k-1];
			end
		end

		if (k < DIV_LAT - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= take ? diff[NW-1:0] : rem_s[k-1];
					den_s[k] <= den_s[k-1];
				end
			end
		end
	end

	assign quo = quo_s[DIV_LAT-1];
	assign ovf = ovf_s[DIV_LAT-1];
	assign neg_out = neg_s[DIV_LAT-1];

endmodule

// ===== rtl/pcb_delay.sv =====
// valid and sideband delay line that runs alongside the divider lanes
module pcb_delay import pcb_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic vin,
	input side_t sin,
	output logic vout,
	output side_t sout
);

	logic v_s [0:DIV_LAT-1];
	side_t sd_s [0:DIV_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DIV_LAT; k++)
				v_s[k] <= 1'b0;
		end else if (en) begin
			v_s[0] <= vin;
			for (int k = 1; k < DIV_LAT; k++)
				v_s[k] <= v_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s[0] <= sin;
			for (int k = 1; k < DIV_LAT; k++)
				sd_s[k] <= sd_s[k-1];
		end
	end

	assign vout = v_s[DIV_LAT-1];
	assign sout = sd_s[DIV_LAT-1];

endmodule

// ===== rtl/pinhole_camera_project_backproject.sv =====
// top level: pipelined pinhole projection, back-projection and image y flip
// throughput: one beat per cycle; the pipeline advances whenever the output register is empty or its beat is taken
// two 35-stage divider banks, one quotient bit per stage, lie in series with the multiplies
// reset: asynchronous, clears all valid bits and the configuration registers to zero
module pinhole_camera_project_backproject import pcb_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [CFG_IW-1:0] cfg_index,
	input logic [REG_W-1:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] cmd,
	input logic camera_sel,
	input logic signed [31:0] coord_a,
	input logic signed [31:0] coord_b,
	input logic signed [31:0] coord_c,
	output logic out_valid,
	input logic out_ready,
	output logic signed [31:0] res_x,
	output logic signed [31:0] res_y,
	output logic signed [31:0] res_z,
	output logic signed [31:0] res_w,
	output logic div_fault
);

	cfg_t cfg;
	logic en;

	pcb_regs u_regs (
		.clk(clk), .arst_n(arst_n), .wr_valid(cfg_valid), .wr_ready(cfg_ready),
		.wr_index(cfg_index), .wr_data(cfg_data), .cfg(cfg)
	);

	logic out_valid_q;
	logic signed [31:0] res_x_q, res_y_q, res_z_q, res_w_q;
	logic fault_q;

	assign en = !out_valid_q || out_ready;
	assign in_ready = en;

	ent_t fx, cx, fy, cy, kz;
	assign fx = ent(cfg.kr[0], 0);
	assign cx = ent(cfg.kr[0], 2);
	assign fy = ent(cfg.kr[1], 1);
	assign cy = ent(cfg.kr[1], 2);
	assign kz = ent(cfg.kr[2], 2);

	// stage 1: rotation products
	logic signed [31:0] pin [3];
	logic signed [33:0] flip_full;
	logic v_s1, cam_s1;
	cmd_t cmd_s1;
	logic signed [31:0] p_s1 [3];
	logic signed [31:0] fy_s1;
	logic signed [52:0] m_s1 [3][3];

	always_comb begin
		pin[0] = coord_a;
		pin[1] = coord_b;
		pin[2] = coord_c;
		flip_full = FLIP_BASE - 34'(coord_b);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1 <= cmd_t'(cmd);
			cam_s1 <= camera_sel;
			fy_s1 <= sat32(64'(flip_full));
			for (int i = 0; i < 3; i++) begin
				p_s1[i] <= pin[i];
				for (int j = 0; j < 3; j++)
					m_s1[i][j] <= ent(cfg.rr[i], j) * pin[j];
			end
		end
	end

	// stage 2: camera frame point
	logic signed [55:0] sum2 [3];
	logic signed [55:0] rnd2 [3];
	logic signed [39:0] a_nx [3];
	logic v_s2, cam_s2;
	cmd_t cmd_s2;
	logic signed [31:0] p_s2 [3];
	logic signed [31:0] fy_s2;
	logic signed [39:0] a_s2 [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sum2[i] = 56'(m_s1[i][0]) + 56'(m_s1[i][1]) + 56'(m_s1[i][2])
				- (56'(ent(cfg.tr[cam_s1], i)) <<< 16);
			rnd2[i] = sum2[i] + 56'sd512;
			a_nx[i] = sat40(64'($signed(rnd2[i][55:10])));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s2 <= cmd_s1;
			cam_s2 <= cam_s1;
			fy_s2 <= fy_s1;
			for (int i = 0; i < 3; i++) begin
				p_s2[i] <= p_s1[i];
				a_s2[i] <= a_nx[i];
			end
		end
	end

	// stage 3: intrinsic products
	logic v_s3, cam_s3;
	cmd_t cmd_s3;
	logic signed [31:0] p_s3 [3];
	logic signed [31:0] fy_s3;
	logic signed [60:0] km_s3 [3][3];

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s3 <= cmd_s2;
			cam_s3 <= cam_s2;
			fy_s3 <= fy_s2;
			for (int i = 0; i < 3; i++) begin
				p_s3[i] <= p_s2[i];
				for (int j = 0; j < 3; j++)
					km_s3[i][j] <= ent(cfg.kr[i], j) * a_s2[j];
			end
		end
	end

	// stage 4: image point
	logic v_s4, cam_s4;
	cmd_t cmd_s4;
	logic signed [31:0] p_s4 [3];
	logic signed [31:0] fy_s4;
	logic signed [62:0] o_s4 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s4 <= cmd_s3;
			cam_s4 <= cam_s3;
			fy_s4 <= fy_s3;
			for (int i = 0; i < 3; i++) begin
				p_s4[i] <= p_s3[i];
				o_s4[i] <= 63'(km_s3[i][0]) + 63'(km_s3[i][1]) + 63'(km_s3[i][2]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// first divider bank operands
	logic [62:0] oabs [3];
	logic [31:0] pabs [3];
	logic [ENT_W-1:0] fxabs, kzabs, fyabs;
	logic signed [62:0] ro [2];
	logic signed [31:0] ro_sat [2];
	logic [NW-1:0] n1 [3];
	logic [DW-1:0] d1 [3];
	logic neg1 [3];
	side_t sin1;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			oabs[i] = o_s4[i][62] ? 63'(-o_s4[i]) : 63'(o_s4[i]);
			pabs[i] = p_s4[i][31] ? 32'(-p_s4[i]) : 32'(p_s4[i]);
		end
		for (int i = 0; i < 2; i++) begin
			ro[i] = o_s4[i] + 63'sd512;
			ro_sat[i] = sat32(64'($signed(ro[i][62:10])));
		end
		fxabs = fx[ENT_W-1] ? ENT_W'(-fx) : ENT_W'(fx);
		kzabs = kz[ENT_W-1] ? ENT_W'(-kz) : ENT_W'(kz);
		fyabs = fy[ENT_W-1] ? ENT_W'(-fy) : ENT_W'(fy);

		for (int i = 0; i < 2; i++) begin
			if (cmd_s4 == CMD_BACKPROJECT) begin
				n1[i] = NW'({pabs[i], 16'd0});
				d1[i] = DW'(pabs[2]);
				neg1[i] = p_s4[i][31] ^ p_s4[2][31];
			end else begin
				n1[i] = NW'({oabs[i], 16'd0});
				d1[i] = DW'(oabs[2]);
				neg1[i] = o_s4[i][62] ^ o_s4[2][62];
			end
		end
		n1[2] = NW'({fxabs, 16'd0});
		d1[2] = DW'(kzabs);
		neg1[2] = fx[ENT_W-1] ^ kz[ENT_W-1];

		sin1 = '0;
		sin1.cmd = cmd_s4;
		sin1.cam = cam_s4;
		if (cmd_s4 == CMD_PROJECT) begin
			sin1.fault = (o_s4[2] == 63'sd0);
			sin1.rx = ro_sat[0];
			sin1.ry = ro_sat[1];
		end else if (cmd_s4 == CMD_BACKPROJECT) begin
			sin1.fault = (p_s4[2] == 32'sd0) || (fx == '0) || (fy == '0) || (kz == '0);
		end else if (cmd_s4 == CMD_FLIP) begin
			sin1.rx = p_s4[0];
			sin1.ry = fy_s4;
			sin1.rz = p_s4[2];
		end
	end

	logic [QW-1:0] q1 [3];
	logic ovf1 [3];
	logic nego1 [3];
	logic v_b1;
	side_t sd_b1;

	for (genvar g = 0; g < 3; g++) begin : g_bank1
		pcb_div_lane u_div (
			.clk(clk), .en(en), .num(n1[g]), .den(d1[g]), .neg(neg1[g]),
			.quo(q1[g]), .ovf(ovf1[g]), .neg_out(nego1[g])
		);
	end

	pcb_delay u_delay1 (
		.clk(clk), .arst_n(arst_n), .en(en), .vin(v_s4), .sin(sin1),
		.vout(v_b1), .sout(sd_b1)
	);

	// stage 5: quotients, project results, offsets removed
	logic signed [31:0] qs1 [3];
	side_t sd_nx5;
	logic signed [33:0] t1_nx;
	logic v_s5;
	side_t sd_s5;
	logic signed [33:0] t1_s5;

	always_comb begin
		for (int i = 0; i < 3; i++)
			qs1[i] = qsat(q1[i], ovf1[i], nego1[i]);
		sd_nx5 = sd_b1;
		t1_nx = 34'(qs1[1]) - (34'(cy) <<< 6);
		if (sd_b1.cmd == CMD_PROJECT && !sd_b1.fault) begin
			sd_nx5.rx = qs1[0];
			sd_nx5.ry = qs1[1];
			sd_nx5.rz = ONE_Q16;
		end
		sd_nx5.a0 = 34'(qs1[0]) - (34'(cx) <<< 6);
		sd_nx5.a2 = qs1[2];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s5 <= sd_nx5;
			t1_s5 <= t1_nx;
		end
	end

	// stage 6: scale by fx
	logic v_s6;
	side_t sd_s6;
	logic signed [54:0] prod_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s6 <= sd_s5;
			prod_s6 <= fx * t1_s5;
		end
	end

	logic [54:0] prod_abs;
	logic [NW-1:0] n2;
	logic [DW-1:0] d2;
	logic neg2;

	always_comb begin
		prod_abs = prod_s6[54] ? 55'(-prod_s6) : 55'(prod_s6);
		n2 = NW'(prod_abs);
		d2 = DW'(fyabs);
		neg2 = prod_s6[54] ^ fy[ENT_W-1];
	end

	logic [QW-1:0] q2;
	logic ovf2, nego2;
	logic v_b2;
	side_t sd_b2;

	pcb_div_lane u_div2 (
		.clk(clk), .en(en), .num(n2), .den(d2), .neg(neg2),
		.quo(q2), .ovf(ovf2), .neg_out(nego2)
	);

	pcb_delay u_delay2 (
		.clk(clk), .arst_n(arst_n), .en(en), .vin(v_s6), .sin(sd_s6),
		.vout(v_b2), .sout(sd_b2)
	);

	// stage 7: transposed rotation products
	logic signed [33:0] aa [3];
	logic v_s7;
	side_t sd_s7;
	logic signed [54:0] rt_s7 [3][3];

	always_comb begin
		aa[0] = sd_b2.a0;
		aa[1] = 34'(qsat(q2, ovf2, nego2));
		aa[2] = 34'(sd_b2.a2);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s7 <= sd_b2;
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					rt_s7[i][j] <= ent(cfg.rr[j], i) * aa[j];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_b1;
			v_s6 <= v_s5;
			v_s7 <= v_b2;
		end
	end

	// output register
	logic signed [56:0] fsum [3];
	logic signed [56:0] frnd [3];
	logic signed [31:0] bval [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			fsum[i] = 57'(rt_s7[i][0]) + 57'(rt_s7[i][1]) + 57'(rt_s7[i][2])
				+ ((i == 0) ? (57'(ent(cfg.tr[sd_s7.cam], 0)) <<< 16) : 57'sd0);
			frnd[i] = fsum[i] + 57'sd512;
			bval[i] = sat32(64'($signed(frnd[i][56:10])));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (en)
			out_valid_q <= v_s7;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fault_q <= sd_s7.fault;
			if (sd_s7.cmd == CMD_BACKPROJECT) begin
				res_w_q <= ONE_Q16;
				res_x_q <= sd_s7.fault ? 32'sd0 : bval[0];
				res_y_q <= sd_s7.fault ? 32'sd0 : bval[1];
				res_z_q <= sd_s7.fault ? 32'sd0 : bval[2];
			end else begin
				res_w_q <= 32'sd0;
				res_x_q <= sd_s7.rx;
				res_y_q <= sd_s7.ry;
				res_z_q <= sd_s7.rz;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign res_x = res_x_q;
	assign res_y = res_y_q;
	assign res_z = res_z_q;
	assign res_w = res_w_q;
	assign div_fault = fault_q;

	a_w_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (res_w == 32'sd0 || res_w == ONE_Q16))
		else $error("homogeneous w out of range");

	a_bp_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && div_fault && res_w == ONE_Q16 |-> res_x == 32'sd0 && res_y == 32'sd0
			&& res_z == 32'sd0)
		else $error("faulted back-projection not cleared");

	a_proj_fault_z: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && div_fault && res_w == 32'sd0 |-> res_z == 32'sd0)
		else $error("faulted projection gives nonzero h");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v_s1) && $stable(v_s4) && $stable(v_s6) && $stable(v_s7))
		else $error("pipeline valid moved during a stall");

endmodule
